FILE: hdl/gnss_imu_heading_fuse_unit_macros.svh
// assertion macros for the heading fusion unit
`ifndef GNSS_IMU_HEADING_FUSE_UNIT_MACROS_SVH
`define GNSS_IMU_HEADING_FUSE_UNIT_MACROS_SVH

// clocked assertion, off while reset is held
`define GIHF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked assertion that also runs during reset
`define GIHF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/gihf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gihf_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package gihf_pkg;

  localparam int XyW        = 40;
  localparam int ZW         = 34;
  localparam int MulW       = 32;
  localparam int ProdW      = 64;
  localparam int Steps      = 30;
  localparam int CntW       = 5;
  localparam int DivSteps   = 4;
  localparam int RemW       = 50;
  localparam int QW         = 26;
  localparam int QsW        = QW + 1;
  localparam int YawW       = 20;
  localparam int HeadW      = 26;
  localparam int BmulLast   = 5;
  localparam int RecipShift = 37;

  localparam logic signed [ZW-1:0]   Deg90      = ZW'(64'sd900000000);
  localparam logic signed [ZW-1:0]   Deg180     = ZW'(64'sd1800000000);
  localparam logic signed [ZW-1:0]   Deg360     = ZW'(64'sd3600000000);
  localparam logic signed [XyW-1:0]  CordicGain = XyW'(64'sd652032874);
  localparam logic signed [XyW-1:0]  Q30One     = XyW'(64'sd1073741824);
  localparam logic [RemW-1:0]        HalfUnit   = RemW'(64'd5000000);
  // one degree unit over 128, and 2^47 over it
  localparam logic signed [MulW-1:0] DivBase    = MulW'(64'sd78125);
  localparam logic signed [MulW-1:0] DivRecip   = MulW'(64'sd1801439850);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_FIRST, S_QMUL, S_QLAST, S_ATQ, S_WRAP, S_SCI, S_SCROT,
    S_SCS, S_BMUL, S_ATB, S_ATROT, S_DIVI, S_DIV, S_YAW, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_FIX, OP_QMUL, OP_QLAST, OP_ATQ, OP_WRAP, OP_SCI,
    OP_ROT, OP_SCS, OP_BMUL, OP_ATB, OP_DIVI, OP_DIV, OP_YAW, OP_OUT
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [CntW-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic prev_vld;
    logic out_busy;
  } sts_t;

  function automatic logic signed [ZW-1:0] atan_step(input logic [CntW-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = ZW'(64'sd450000000);
      5'd1:  r = ZW'(64'sd265650512);
      5'd2:  r = ZW'(64'sd140362435);
      5'd3:  r = ZW'(64'sd71250163);
      5'd4:  r = ZW'(64'sd35763344);
      5'd5:  r = ZW'(64'sd17899106);
      5'd6:  r = ZW'(64'sd8951737);
      5'd7:  r = ZW'(64'sd4476142);
      5'd8:  r = ZW'(64'sd2238105);
      5'd9:  r = ZW'(64'sd1119057);
      5'd10: r = ZW'(64'sd559529);
      5'd11: r = ZW'(64'sd279765);
      5'd12: r = ZW'(64'sd139882);
      5'd13: r = ZW'(64'sd69941);
      5'd14: r = ZW'(64'sd34971);
      5'd15: r = ZW'(64'sd17485);
      5'd16: r = ZW'(64'sd8743);
      5'd17: r = ZW'(64'sd4371);
      5'd18: r = ZW'(64'sd2186);
      5'd19: r = ZW'(64'sd1093);
      5'd20: r = ZW'(64'sd546);
      5'd21: r = ZW'(64'sd273);
      5'd22: r = ZW'(64'sd137);
      5'd23: r = ZW'(64'sd68);
      5'd24: r = ZW'(64'sd34);
      5'd25: r = ZW'(64'sd17);
      5'd26: r = ZW'(64'sd9);
      5'd27: r = ZW'(64'sd4);
      5'd28: r = ZW'(64'sd2);
      5'd29: r = ZW'(64'sd1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/gnss_imu_heading_fuse_unit.sv
`timescale 1ns / 1ps
// orientation beat: busy after acceptance through four multiplies, 30 cordic steps and
//   a reciprocal divide; no new beat is taken until it is done
// position fix beat: result valid after three sine/cosine passes, four multiplies, a
//   30-step arctangent and a divide; no new beat is taken before the result is out,
//   nor while a waiting result stalls; a first fix only stores the position, with no result
// reset (async, active low) clears the stored yaw, the previous fix and its valid flag
// ----------------------------------------------------------------------------
// gnss_imu_heading_fuse_unit
// fuses imu yaw with the great-circle bearing between successive gnss fixes
// ----------------------------------------------------------------------------
module gnss_imu_heading_fuse_unit import gihf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    action_i,
  input  logic signed [15:0]      quat_w_i,
  input  logic signed [15:0]      quat_x_i,
  input  logic signed [15:0]      quat_y_i,
  input  logic signed [15:0]      quat_z_i,
  input  logic signed [30:0]      latitude_i,
  input  logic signed [31:0]      longitude_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [HeadW-1:0] heading_o
);

  cmd_t cmd;
  sts_t sts;

  gihf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gihf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (action_i),
    .quat_w_i    (quat_w_i),
    .quat_x_i    (quat_x_i),
    .quat_y_i    (quat_y_i),
    .quat_z_i    (quat_z_i),
    .latitude_i  (latitude_i),
    .longitude_i (longitude_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .heading_o   (heading_o)
  );

endmodule

FILE: hdl/gihf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gihf_ctrl
// sequencer that steps the datapath through yaw and bearing computations
// ----------------------------------------------------------------------------
module gihf_ctrl import gihf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      idx_q, idx_d;
  logic            fix_q, fix_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DISP;
      S_DISP:   state_d = sts_i.action ? (sts_i.prev_vld ? S_WRAP : S_FIRST) : S_QMUL;
      S_FIRST:  state_d = S_IDLE;
      S_QMUL:   if (cnt_q == CntW'(3)) state_d = S_QLAST;
      S_QLAST:  state_d = S_ATQ;
      S_ATQ:    state_d = S_ATROT;
      S_WRAP:   state_d = S_SCI;
      S_SCI:    state_d = S_SCROT;
      S_SCROT:  if (cnt_q == CntW'(Steps - 1)) state_d = S_SCS;
      S_SCS:    state_d = (idx_q == 2'd2) ? S_BMUL : S_WRAP;
      S_BMUL:   if (cnt_q == CntW'(BmulLast)) state_d = S_ATB;
      S_ATB:    state_d = S_ATROT;
      S_ATROT:  if (cnt_q == CntW'(Steps - 1)) state_d = S_DIVI;
      S_DIVI:   state_d = S_DIV;
      S_DIV:    if (cnt_q == CntW'(DivSteps - 1)) state_d = fix_q ? S_OUT : S_YAW;
      S_YAW:    state_d = S_IDLE;
      S_OUT:    if (!sts_i.out_busy) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = (state_d != state_q) ? '0 : cnt_q + CntW'(1);
    idx_d = idx_q;
    fix_d = fix_q;
    if (state_q == S_DISP) begin
      idx_d = '0;
      fix_d = sts_i.action;
    end else if (state_q == S_SCS) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.step = cnt_q;
    unique case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_FIRST: cmd_o.op = OP_FIX;
      S_QMUL:  cmd_o.op = OP_QMUL;
      S_QLAST: cmd_o.op = OP_QLAST;
      S_ATQ:   cmd_o.op = OP_ATQ;
      S_WRAP: begin
        cmd_o.op   = OP_WRAP;
        cmd_o.step = CntW'(idx_q);
      end
      S_SCI:   cmd_o.op = OP_SCI;
      S_SCROT: cmd_o.op = OP_ROT;
      S_SCS: begin
        cmd_o.op   = OP_SCS;
        cmd_o.step = CntW'(idx_q);
      end
      S_BMUL:  cmd_o.op = OP_BMUL;
      S_ATB:   cmd_o.op = OP_ATB;
      S_ATROT: cmd_o.op = OP_ROT;
      S_DIVI: begin
        cmd_o.op   = OP_DIVI;
        cmd_o.step = CntW'(fix_q);
      end
      S_DIV:   cmd_o.op = OP_DIV;
      S_YAW:   cmd_o.op = OP_YAW;
      S_OUT:   cmd_o.op = sts_i.out_busy ? OP_NONE : OP_OUT;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      fix_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      fix_q   <= fix_d;
    end
  end

endmodule

FILE: hdl/gihf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gihf_datapath
// shared cordic, multiplier and rounding divider with the held state
// ----------------------------------------------------------------------------
module gihf_datapath import gihf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic                     action_i,
  input  logic signed [15:0]       quat_w_i,
  input  logic signed [15:0]       quat_x_i,
  input  logic signed [15:0]       quat_y_i,
  input  logic signed [15:0]       quat_z_i,
  input  logic signed [30:0]       latitude_i,
  input  logic signed [31:0]       longitude_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [HeadW-1:0]  heading_o
);

  logic                    act_q;
  logic signed [15:0]      qw_q, qx_q, qy_q, qz_q;
  logic signed [30:0]      lat_q, prev_lat_q;
  logic signed [31:0]      lon_q, prev_lon_q;
  logic                    prev_vld_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ZW-1:0]    acc_a_q, acc_b_q;
  logic signed [XyW-1:0]   x_q, y_q;
  logic signed [ZW-1:0]    z_q, ang_q;
  logic                    rot_mode_q, zero_q, neg_q;
  logic signed [MulW-1:0]  s1_q, c1_q, s2_q, c2_q, sd_q, cd_q;
  logic signed [ZW-1:0]    t1_q, t2_q, t3_q;
  logic [RemW-1:0]         r_q;
  logic [QW-1:0]           q_q;
  logic                    dneg_q;
  logic signed [YawW-1:0]  yaw_q;
  logic signed [HeadW-1:0] heading_q;
  logic                    out_valid_q;

  logic signed [MulW-1:0]  ma, mb;
  logic signed [ZW-1:0]    wrap_in, sc_a, div_a;
  logic                    sc_neg;
  logic signed [XyW-1:0]   at_x, at_y, xs, ys;
  logic                    rot_dir;
  logic [ZW-1:0]           div_mag;
  logic [RemW-1:0]         div_rem;
  logic signed [QsW-1:0]   qs;
  logic signed [24:0]      yaw_sh;

  function automatic logic signed [ZW-1:0] wrap360(input logic signed [ZW-1:0] a);
    logic signed [ZW-1:0] m;
    m = a;
    if (m >= Deg360) m = m - Deg360;
    else if (m <= -Deg360) m = m + Deg360;
    if (m > Deg180) m = m - Deg360;
    else if (m <= -Deg180) m = m + Deg360;
    return m;
  endfunction

  function automatic logic signed [ZW-1:0] qtrunc(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] b;
    b = p + ((p < 0) ? ProdW'(64'sd1073741823) : '0);
    return ZW'(b >>> 30);
  endfunction

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd_i.op == OP_QMUL) begin
      case (cmd_i.step[1:0])
        2'd0:    begin ma = MulW'(qw_q); mb = MulW'(qz_q); end
        2'd1:    begin ma = MulW'(qx_q); mb = MulW'(qy_q); end
        2'd2:    begin ma = MulW'(qy_q); mb = MulW'(qy_q); end
        default: begin ma = MulW'(qz_q); mb = MulW'(qz_q); end
      endcase
    end else if (cmd_i.op == OP_BMUL) begin
      case (cmd_i.step)
        5'd0:    begin ma = c1_q; mb = s2_q; end
        5'd1:    begin ma = s1_q; mb = c2_q; end
        5'd3:    begin ma = MulW'(t2_q); mb = cd_q; end
        5'd4:    begin ma = sd_q; mb = c2_q; end
        default: begin ma = '0; mb = '0; end
      endcase
    end else if (cmd_i.op == OP_DIV) begin
      // quotient estimate by reciprocal, then back-multiply for the remainder
      if (cmd_i.step[1]) begin
        ma = MulW'(q_q);
        mb = DivBase;
      end else begin
        ma = MulW'(r_q >> 10);
        mb = DivRecip;
      end
    end
  end

  always_comb begin
    case (cmd_i.step[1:0])
      2'd0:    wrap_in = ZW'(prev_lat_q);
      2'd1:    wrap_in = ZW'(lat_q);
      default: wrap_in = ZW'(lon_q) - ZW'(prev_lon_q);
    endcase
  end

  // fold into the cordic convergence range
  always_comb begin
    sc_a   = ang_q;
    sc_neg = 1'b0;
    if (ang_q > Deg90) begin
      sc_a   = ang_q - Deg180;
      sc_neg = 1'b1;
    end else if (ang_q < -Deg90) begin
      sc_a   = ang_q + Deg180;
      sc_neg = 1'b1;
    end
  end

  always_comb begin
    if (cmd_i.op == OP_ATQ) begin
      at_y = XyW'(acc_a_q) <<< 1;
      at_x = Q30One - (XyW'(acc_b_q) <<< 1);
    end else begin
      at_y = XyW'(t2_q);
      at_x = XyW'(t1_q) - XyW'(t3_q);
    end
  end

  assign xs      = x_q >>> cmd_i.step;
  assign ys      = y_q >>> cmd_i.step;
  assign rot_dir = rot_mode_q ? !z_q[ZW-1] : y_q[XyW-1];

  assign div_a   = zero_q ? '0 : z_q;
  assign div_mag = div_a[ZW-1] ? ZW'(-div_a) : ZW'(div_a);
  assign div_rem = r_q - RemW'(prod_q);
  assign qs      = dneg_q ? -QsW'(q_q) : QsW'(q_q);
  assign yaw_sh  = {yaw_q, 5'b0};

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        act_q <= action_i;
        qw_q  <= quat_w_i;
        qx_q  <= quat_x_i;
        qy_q  <= quat_y_i;
        qz_q  <= quat_z_i;
        lat_q <= latitude_i;
        lon_q <= longitude_i;
      end
      OP_QMUL: begin
        prod_q <= ProdW'(ma) * ProdW'(mb);
        case (cmd_i.step[1:0])
          2'd1:    acc_a_q <= ZW'(prod_q);
          2'd2:    acc_a_q <= acc_a_q + ZW'(prod_q);
          2'd3:    acc_b_q <= ZW'(prod_q);
          default: acc_a_q <= acc_a_q;
        endcase
      end
      OP_QLAST: acc_b_q <= acc_b_q + ZW'(prod_q);
      OP_ATQ, OP_ATB: begin
        zero_q     <= (at_x == '0) && (at_y == '0);
        rot_mode_q <= 1'b0;
        if (at_x[XyW-1]) begin
          x_q <= -at_x;
          y_q <= -at_y;
          z_q <= at_y[XyW-1] ? -Deg180 : Deg180;
        end else begin
          x_q <= at_x;
          y_q <= at_y;
          z_q <= '0;
        end
      end
      OP_WRAP: ang_q <= wrap360(wrap_in);
      OP_SCI: begin
        x_q        <= CordicGain;
        y_q        <= '0;
        z_q        <= sc_a;
        neg_q      <= sc_neg;
        rot_mode_q <= 1'b1;
      end
      OP_ROT: begin
        if (rot_dir) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_step(cmd_i.step);
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_step(cmd_i.step);
        end
      end
      OP_SCS: begin
        case (cmd_i.step[1:0])
          2'd0: begin
            s1_q <= MulW'(neg_q ? -y_q : y_q);
            c1_q <= MulW'(neg_q ? -x_q : x_q);
          end
          2'd1: begin
            s2_q <= MulW'(neg_q ? -y_q : y_q);
            c2_q <= MulW'(neg_q ? -x_q : x_q);
          end
          default: begin
            sd_q <= MulW'(neg_q ? -y_q : y_q);
            cd_q <= MulW'(neg_q ? -x_q : x_q);
          end
        endcase
      end
      OP_BMUL: begin
        prod_q <= ProdW'(ma) * ProdW'(mb);
        case (cmd_i.step)
          5'd1:    t1_q <= qtrunc(prod_q);
          5'd2:    t2_q <= qtrunc(prod_q);
          5'd4:    t3_q <= qtrunc(prod_q);
          5'd5:    t2_q <= qtrunc(prod_q);
          default: t1_q <= t1_q;
        endcase
      end
      OP_DIVI: begin
        // rounding offset added, low seven bits of the unit dropped up front
        r_q    <= ((cmd_i.step[0] ? (RemW'(div_mag) << 16) : (RemW'(div_mag) << 11))
                   + HalfUnit) >> 7;
        q_q    <= '0;
        dneg_q <= div_a[ZW-1];
      end
      OP_DIV: begin
        prod_q <= ProdW'(ma) * ProdW'(mb);
        case (cmd_i.step[1:0])
          2'd1:    q_q <= QW'(prod_q >>> RecipShift);
          2'd3:    if (div_rem >= RemW'(DivBase)) q_q <= q_q + QW'(1);
          default: q_q <= q_q;
        endcase
      end
      OP_OUT: heading_q <= qs[HeadW-1:0] + HeadW'(yaw_sh);
      default: act_q <= act_q;
    endcase
  end

  // held state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q       <= '0;
      prev_lat_q  <= '0;
      prev_lon_q  <= '0;
      prev_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_YAW: yaw_q <= qs[YawW-1:0];
        OP_FIX, OP_OUT: begin
          prev_lat_q <= lat_q;
          prev_lon_q <= lon_q;
          prev_vld_q <= 1'b1;
          if (cmd_i.op == OP_OUT) out_valid_q <= 1'b1;
        end
        default: prev_vld_q <= prev_vld_q;
      endcase
    end
  end

  assign sts_o.action   = act_q;
  assign sts_o.prev_vld = prev_vld_q;
  assign sts_o.out_busy = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign heading_o      = heading_q;

endmodule

FILE: hdl/gihf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gihf_checker
// port-level checks on the heading fusion unit
// ----------------------------------------------------------------------------
`include "gnss_imu_heading_fuse_unit_macros.svh"

module gihf_checker import gihf_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    action_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [HeadW-1:0] heading_o
);

  `GIHF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(heading_o), "result beat dropped or changed while stalled")
  `GIHF_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "input taken while a beat is in flight")
  `GIHF_ASSERT(a_result_from_busy, $rose(out_valid_o) |-> $past(!in_ready_o), "result appeared without a beat in flight")
  `GIHF_ASSERT_ALWAYS(a_orient_no_result, rst_ni && in_valid_i && in_ready_o && !action_i |=> !$rose(out_valid_o), "orientation beat produced a result")

endmodule

bind gnss_imu_heading_fuse_unit gihf_checker u_gihf_checker (.*);
